### src/oams_pkg.sv
package oams_pkg;

    // Drive modes; the codes are also the command codes on the result channel.
    typedef enum logic [1:0] {
        MODE_STOP    = 2'd0,
        MODE_FORWARD = 2'd1,
        MODE_LEFT    = 2'd2,
        MODE_RIGHT   = 2'd3
    } mode_t;

    // Configuration register indexes.
    localparam int CfgIndexW = 3;
    localparam logic [CfgIndexW-1:0] CFG_OBSTACLE_THRESHOLD = 3'd0;
    localparam logic [CfgIndexW-1:0] CFG_CLEAR_THRESHOLD    = 3'd1;
    localparam logic [CfgIndexW-1:0] CFG_STOP_DURATION      = 3'd2;
    localparam logic [CfgIndexW-1:0] CFG_TURN_DURATION      = 3'd3;
    localparam logic [CfgIndexW-1:0] CFG_RANDOM_SEED        = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [15:0] OBSTACLE_THRESHOLD_RST = 16'd480;
    localparam logic [15:0] CLEAR_THRESHOLD_RST    = 16'd640;
    localparam logic [15:0] STOP_DURATION_RST      = 16'd500;
    localparam logic [15:0] TURN_DURATION_RST      = 16'd400;
    localparam logic [31:0] RANDOM_SEED_RST        = 32'd0;

    // Generator value used when the seed is zero, and at reset.
    localparam logic [31:0] SEED_DEFAULT = 32'h6D2B79F5;

    // Current configuration, as seen by the step logic.
    typedef struct packed {
        logic [15:0] obstacle_threshold;
        logic [15:0] clear_threshold;
        logic [15:0] stop_duration;
        logic [15:0] turn_duration;
        logic [31:0] random_seed;
    } cfg_t;

    // Sequencer state carried from one word to the next.
    typedef struct packed {
        mode_t       mode;
        logic        fault;
        logic [31:0] entered_at;
        logic [31:0] generator;
    } seq_state_t;

    // One input word.
    typedef struct packed {
        logic        op;
        logic [31:0] now_ms;
        logic        distance_valid;
        logic [15:0] distance_fixed;
    } item_t;

    // One xorshift step: shifts of 13 left, 17 right and 5 left.
    function automatic logic [31:0] xorshift32(input logic [31:0] v_in);
        logic [31:0] v;
        begin
            v = v_in;
            v = v ^ (v << 13);
            v = v ^ (v >> 17);
            v = v ^ (v << 5);
            return v;
        end
    endfunction

endpackage

### src/oams_cfg_regs.sv
module oams_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [oams_pkg::CfgIndexW-1:0] wr_index,
    input  logic [31:0]                   wr_data,
    output oams_pkg::cfg_t                cfg
);

    logic [15:0] obstacle_threshold_reg;
    logic [15:0] clear_threshold_reg;
    logic [15:0] stop_duration_reg;
    logic [15:0] turn_duration_reg;
    logic [31:0] random_seed_reg;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obstacle_threshold_reg <= oams_pkg::OBSTACLE_THRESHOLD_RST;
            clear_threshold_reg    <= oams_pkg::CLEAR_THRESHOLD_RST;
            stop_duration_reg      <= oams_pkg::STOP_DURATION_RST;
            turn_duration_reg      <= oams_pkg::TURN_DURATION_RST;
            random_seed_reg        <= oams_pkg::RANDOM_SEED_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                oams_pkg::CFG_OBSTACLE_THRESHOLD: obstacle_threshold_reg <= wr_data[15:0];
                oams_pkg::CFG_CLEAR_THRESHOLD:    clear_threshold_reg    <= wr_data[15:0];
                oams_pkg::CFG_STOP_DURATION:      stop_duration_reg      <= wr_data[15:0];
                oams_pkg::CFG_TURN_DURATION:      turn_duration_reg      <= wr_data[15:0];
                oams_pkg::CFG_RANDOM_SEED:        random_seed_reg        <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg.obstacle_threshold = obstacle_threshold_reg;
    assign cfg.clear_threshold    = clear_threshold_reg;
    assign cfg.stop_duration      = stop_duration_reg;
    assign cfg.turn_duration      = turn_duration_reg;
    assign cfg.random_seed        = random_seed_reg;

endmodule

### src/oams_step.sv
module oams_step (
    input  oams_pkg::item_t      item,
    input  oams_pkg::cfg_t       cfg,
    input  oams_pkg::seq_state_t cur,
    output oams_pkg::seq_state_t nxt,
    output oams_pkg::mode_t      cmd
);

    logic [31:0] elapsed;
    logic [31:0] gen_stepped;
    logic        is_clear;
    logic        is_blocked;
    logic        stop_done;
    logic        turn_done;

    // Elapsed time wraps with the millisecond counter.
    assign elapsed     = item.now_ms - cur.entered_at;
    assign gen_stepped = oams_pkg::xorshift32(cur.generator);
    assign is_clear    = item.distance_fixed >= cfg.clear_threshold;
    assign is_blocked  = item.distance_fixed < cfg.obstacle_threshold;
    assign stop_done   = elapsed >= {16'd0, cfg.stop_duration};
    assign turn_done   = elapsed >= {16'd0, cfg.turn_duration};

    // Mode transitions for one word.
    always_comb
    begin
        nxt = cur;
        cmd = oams_pkg::MODE_STOP;
        if (item.op)
        begin
            // Restart reloads the generator and holds a fault stop.
            nxt.generator  = (cfg.random_seed == 32'd0) ? oams_pkg::SEED_DEFAULT
                                                        : cfg.random_seed;
            nxt.fault      = 1'b1;
            nxt.mode       = oams_pkg::MODE_STOP;
            nxt.entered_at = item.now_ms;
        end
        else if (!item.distance_valid)
        begin
            // A bad reading stops the car; an existing fault stop keeps its start time.
            if (!cur.fault || cur.mode != oams_pkg::MODE_STOP)
            begin
                nxt.mode       = oams_pkg::MODE_STOP;
                nxt.entered_at = item.now_ms;
            end
            nxt.fault = 1'b1;
        end
        else
        begin
            case (cur.mode)
                oams_pkg::MODE_FORWARD:
                begin
                    if (is_blocked)
                    begin
                        nxt.mode       = oams_pkg::MODE_STOP;
                        nxt.entered_at = item.now_ms;
                        nxt.fault      = 1'b0;
                        cmd            = oams_pkg::MODE_STOP;
                    end
                    else
                    begin
                        cmd = oams_pkg::MODE_FORWARD;
                    end
                end
                oams_pkg::MODE_STOP:
                begin
                    if (cur.fault)
                    begin
                        // First good reading after a fault.
                        nxt.fault      = 1'b0;
                        nxt.entered_at = item.now_ms;
                        if (is_clear)
                        begin
                            nxt.mode = oams_pkg::MODE_FORWARD;
                            cmd      = oams_pkg::MODE_FORWARD;
                        end
                        else
                        begin
                            nxt.mode = oams_pkg::MODE_STOP;
                            cmd      = oams_pkg::MODE_STOP;
                        end
                    end
                    else if (stop_done)
                    begin
                        // The generator's low bit picks the turn side.
                        nxt.generator  = gen_stepped;
                        nxt.entered_at = item.now_ms;
                        if (gen_stepped[0])
                        begin
                            nxt.mode = oams_pkg::MODE_RIGHT;
                            cmd      = oams_pkg::MODE_RIGHT;
                        end
                        else
                        begin
                            nxt.mode = oams_pkg::MODE_LEFT;
                            cmd      = oams_pkg::MODE_LEFT;
                        end
                    end
                    else
                    begin
                        cmd = oams_pkg::MODE_STOP;
                    end
                end
                default:
                begin
                    // Turning left or right.
                    if (turn_done)
                    begin
                        nxt.entered_at = item.now_ms;
                        if (!is_clear)
                        begin
                            nxt.mode  = oams_pkg::MODE_STOP;
                            nxt.fault = 1'b0;
                            cmd       = oams_pkg::MODE_STOP;
                        end
                        else
                        begin
                            nxt.mode = oams_pkg::MODE_FORWARD;
                            cmd      = oams_pkg::MODE_FORWARD;
                        end
                    end
                    else
                    begin
                        cmd = cur.mode;
                    end
                end
            endcase
        end
    end

endmodule

### src/obstacle_avoid_mode_sequencer.sv
// Channel   Handshake                    Payload
// item      item_valid / item_stall      op, now_ms, distance_valid, distance_fixed
// result    result_valid / result_stall  command, fault_hold
// cfg       cfg_valid / cfg_ready        cfg_index, cfg_data
//
// A word passes through an input register and the step logic into the result
// register.
// One word is accepted per cycle while item_stall is low; the mode state updates as the result loads.
// Reset puts the car in a fault stop with the default generator and thresholds.
// A stalled result holds the pipeline; the input register keeps the next word
// and item_stall rises only while both registers are full.
module obstacle_avoid_mode_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic                           op,
    input  logic [31:0]                    now_ms,
    input  logic                           distance_valid,
    input  logic [15:0]                    distance_fixed,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [1:0]                     command,
    output logic                           fault_hold,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [oams_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    oams_pkg::cfg_t       cfg;
    oams_pkg::item_t      in_reg;
    oams_pkg::seq_state_t state_reg;
    oams_pkg::seq_state_t state_next;
    oams_pkg::mode_t      cmd_next;
    logic                 in_valid_reg;
    logic                 result_valid_reg;
    logic [1:0]           command_reg;
    logic                 fault_hold_reg;
    logic                 result_free;
    logic                 result_load;
    logic                 in_load;

    // Configuration is always accepted.
    assign cfg_ready = 1'b1;

    oams_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Pipeline flow control.
    assign result_free = !result_valid_reg || !result_stall;
    assign result_load = in_valid_reg && result_free;
    assign item_stall  = in_valid_reg && !result_free;
    assign in_load     = item_valid && !item_stall;

    // Input register valid and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (result_load)
            begin
                in_valid_reg <= 1'b0;
            end
            if (result_free)
            begin
                result_valid_reg <= in_valid_reg;
            end
        end
    end

    // Input word payload.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_reg.op             <= op;
            in_reg.now_ms         <= now_ms;
            in_reg.distance_valid <= distance_valid;
            in_reg.distance_fixed <= distance_fixed;
        end
    end

    oams_step u_step (
        .item (in_reg),
        .cfg  (cfg),
        .cur  (state_reg),
        .nxt  (state_next),
        .cmd  (cmd_next)
    );

    // Sequencer state advances as each result is loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode       <= oams_pkg::MODE_STOP;
            state_reg.fault      <= 1'b1;
            state_reg.entered_at <= 32'd0;
            state_reg.generator  <= oams_pkg::SEED_DEFAULT;
        end
        else if (result_load)
        begin
            state_reg <= state_next;
        end
    end

    // Result word payload.
    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            command_reg    <= cmd_next;
            fault_hold_reg <= state_next.fault;
        end
    end

    assign result_valid = result_valid_reg;
    assign command      = command_reg;
    assign fault_hold   = fault_hold_reg;

    // A fault always goes with the stop mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.fault |-> (state_reg.mode == oams_pkg::MODE_STOP))
        else $error("fault flag set outside stop mode");

    // The xorshift generator must never reach the all-zero lock-up value.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.generator != 32'd0)
        else $error("generator reached zero");

    // A restart word yields a fault stop.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_load && in_reg.op) |=>
            (fault_hold && command == oams_pkg::MODE_STOP))
        else $error("restart did not give a fault stop");

    // The input side stalls only while a word is held in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (in_valid_reg && result_valid_reg && result_stall))
        else $error("input stalled without a held word");

endmodule
